@@ sv/lru_frame_replacer_unit_assert.svh @@
// ----------------------------------------------------------------------------
// LRU frame replacer: assertion macros
// Invariant and implication checks shared by the replacer RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_FRAME_REPLACER_UNIT_ASSERT_SVH
`define LRU_FRAME_REPLACER_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define LFR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lfr assertion failed: same-cycle check");

// Check that cons holds in the cycle after ante, outside reset.
`define LFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfr assertion failed: next-cycle check");

`endif

@@ sv/lfr_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU frame replacer package
// Shared widths, command codes and the cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lfr_pkg;

   localparam int unsigned FRAME_W        = 6;
   localparam int unsigned COUNT_W        = 7;
   localparam int unsigned CMD_W          = 2;
   localparam int unsigned NUM_FRAMES_DEF = 64;
   localparam logic [COUNT_W-1:0] CAPACITY_RST = 7'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_UNPIN  = 2'd0,
      CMD_PIN    = 2'd1,
      CMD_VICTIM = 2'd2
   } cmd_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic               capture;      // latch match against cmp_fid
      logic [FRAME_W-1:0] cmp_fid;
      logic               pin_shift;    // close the gap left by the matched cell
      logic               victim_shift; // drop the head, whole row moves up
      logic               unpin_write;  // append at the first empty cell
      logic [FRAME_W-1:0] wr_fid;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ sv/lfr_req_if.sv @@
// ----------------------------------------------------------------------------
// LRU frame replacer request channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfr_req_if;
   logic                        valid;
   logic                        ready;
   logic [lfr_pkg::CMD_W-1:0]   cmd;
   logic [lfr_pkg::FRAME_W-1:0] frame_no;

   modport source (output valid, output cmd, output frame_no, input ready);
   modport sink   (input valid, input cmd, input frame_no, output ready);
endinterface

`default_nettype wire

@@ sv/lfr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// LRU frame replacer response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic [lfr_pkg::FRAME_W-1:0] victim_frame;
   logic                        ignored;
   logic [lfr_pkg::COUNT_W-1:0] occupancy;

   modport source (output valid, output found, output victim_frame,
                   output ignored, output occupancy, input ready);
   modport sink   (input valid, input found, input victim_frame,
                   input ignored, input occupancy, output ready);
endinterface

`default_nettype wire

@@ sv/lfr_cell.sv @@
// ----------------------------------------------------------------------------
// LRU frame replacer cell
// One slot of the recency row: frame number, valid bit and match flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lfr_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lfr_pkg::cell_ctrl_type      ctrl,
   input  wire logic                        prev_valid,
   input  wire logic                        next_valid,
   input  wire logic [lfr_pkg::FRAME_W-1:0] next_value,
   input  wire logic                        prefix_in,
   output      logic                        valid,
   output      logic [lfr_pkg::FRAME_W-1:0] value,
   output      logic                        prefix_out
);

   logic                        valid_ff;
   logic                        match_ff;
   logic [lfr_pkg::FRAME_W-1:0] value_ff;
   logic                        shift;
   logic                        write;

   // matched here or in an older cell: pull from the younger neighbour
   assign prefix_out = prefix_in | match_ff;
   assign shift      = ctrl.victim_shift | (ctrl.pin_shift & prefix_out);
   assign write      = ctrl.unpin_write & ~valid_ff & prev_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         if (shift) begin
            valid_ff <= next_valid;
         end else if (write) begin
            valid_ff <= 1'b1;
         end
         if (ctrl.capture) begin
            match_ff <= valid_ff & (value_ff == ctrl.cmp_fid);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         value_ff <= next_value;
      end else if (write) begin
         value_ff <= ctrl.wr_fid;
      end
   end

   assign valid = valid_ff;
   assign value = value_ff;

endmodule

`default_nettype wire

@@ sv/lfr_chain.sv @@
// ----------------------------------------------------------------------------
// LRU frame replacer chain
// Row of cells, oldest frame at the head, match prefix rippling down the row.
// ----------------------------------------------------------------------------
`default_nettype none

module lfr_chain #(
   parameter int unsigned NUM_FRAMES = lfr_pkg::NUM_FRAMES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lfr_pkg::cell_ctrl_type      ctrl,
   output      logic                        hit,
   output      logic                        head_valid,
   output      logic [lfr_pkg::FRAME_W-1:0] head_value
);

   logic                        valid_w  [NUM_FRAMES];
   logic [lfr_pkg::FRAME_W-1:0] value_w  [NUM_FRAMES];
   logic                        prefix_w [NUM_FRAMES+1];

   assign prefix_w[0] = 1'b0;

   for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
      logic                        prev_v;
      logic                        next_v;
      logic [lfr_pkg::FRAME_W-1:0] next_d;

      if (i == 0) begin : g_head
         assign prev_v = 1'b1;
      end else begin : g_body
         assign prev_v = valid_w[i-1];
      end

      if (i == NUM_FRAMES - 1) begin : g_tail
         assign next_v = 1'b0;
         assign next_d = '0;
      end else begin : g_link
         assign next_v = valid_w[i+1];
         assign next_d = value_w[i+1];
      end

      lfr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_valid (prev_v),
         .next_valid (next_v),
         .next_value (next_d),
         .prefix_in  (prefix_w[i]),
         .valid      (valid_w[i]),
         .value      (value_w[i]),
         .prefix_out (prefix_w[i+1])
      );
   end

   assign hit        = prefix_w[NUM_FRAMES];
   assign head_valid = valid_w[0];
   assign head_value = value_w[0];

endmodule

`default_nettype wire

@@ sv/lru_frame_replacer_unit.sv @@
// ----------------------------------------------------------------------------
// LRU frame replacer unit
// Least-recently-unpinned frame replacement policy on a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one command word (cmd, frame_no): unpin appends the frame
//   at the young end, pin removes it, victim removes and returns the oldest.
//   rsp_chan returns exactly one result word per command: found, victim_frame,
//   ignored and the occupancy after the operation.
//   csr_wr_en/csr_wr_data write the capacity; write it only while idle.
//   The accepting edge latches every cell's compare against frame_no; the
//   update step in ST_APPLY then ripples the match along the row, shifts or
//   appends cells and loads the result word into the output register. No new
//   command is taken until that update step is done.
//   A new request is taken while an earlier result still waits in the output
//   register; if the receiver stalls, the update step holds until the
//   waiting word is taken, and req_chan.ready stays low meanwhile.
//   Reset empties the row, clears the occupancy and sets capacity to 64.
//   No clearing pass follows reset; the block is ready on the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_frame_replacer_unit_assert.svh"

module lru_frame_replacer_unit #(
   parameter int unsigned NUM_FRAMES = lfr_pkg::NUM_FRAMES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   lfr_req_if.sink                          req_chan,
   lfr_rsp_if.source                        rsp_chan,
   input  wire logic                        csr_wr_en,
   input  wire logic [lfr_pkg::COUNT_W-1:0] csr_wr_data
);

   typedef enum logic {
      ST_IDLE,
      ST_APPLY
   } state_type;

   state_type                   state_ff;
   logic [lfr_pkg::COUNT_W-1:0] capacity_ff;
   logic [lfr_pkg::COUNT_W-1:0] count_ff;
   logic [lfr_pkg::COUNT_W-1:0] count_in;
   logic [lfr_pkg::CMD_W-1:0]   cmd_ff;
   logic [lfr_pkg::FRAME_W-1:0] fid_ff;

   logic                        rsp_valid_ff;
   logic                        rsp_found_ff;
   logic [lfr_pkg::FRAME_W-1:0] rsp_victim_ff;
   logic                        rsp_ignored_ff;
   logic [lfr_pkg::COUNT_W-1:0] rsp_occ_ff;

   lfr_pkg::cell_ctrl_type      ctrl;
   logic                        hit;
   logic                        head_valid;
   logic [lfr_pkg::FRAME_W-1:0] head_value;

   logic                        accept;
   logic                        apply_go;
   logic                        in_range;
   logic                        unpin_ok;
   logic                        pin_ok;
   logic                        victim_ok;
   logic                        ignored_in;

   // take a word only between commands; the output register decouples rsp
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid & req_chan.ready;
   // hold the update while the previous result is still unclaimed
   assign apply_go       = (state_ff == ST_APPLY) & (~rsp_valid_ff | rsp_chan.ready);

   // frames at or above the row's depth are never held
   assign in_range  = (32'(fid_ff) < NUM_FRAMES);
   assign unpin_ok  = (cmd_ff == lfr_pkg::CMD_UNPIN) & in_range & ~hit &
                      (count_ff < capacity_ff) & (32'(count_ff) < NUM_FRAMES);
   assign pin_ok    = (cmd_ff == lfr_pkg::CMD_PIN) & in_range & hit;
   assign victim_ok = (cmd_ff == lfr_pkg::CMD_VICTIM) & (count_ff != '0);

   always_comb begin
      count_in   = count_ff;
      ignored_in = 1'b0;
      unique case (cmd_ff)
         lfr_pkg::CMD_UNPIN: begin
            ignored_in = ~unpin_ok;
            if (unpin_ok) begin
               count_in = count_ff + 1'b1;
            end
         end
         lfr_pkg::CMD_PIN: begin
            ignored_in = ~pin_ok;
            if (pin_ok) begin
               count_in = count_ff - 1'b1;
            end
         end
         lfr_pkg::CMD_VICTIM: begin
            if (victim_ok) begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            ignored_in = 1'b1;
         end
      endcase
   end

   // broadcast to the row: compare on accept, shift or append on update
   always_comb begin
      ctrl.capture      = accept;
      ctrl.cmp_fid      = req_chan.frame_no;
      ctrl.pin_shift    = apply_go & pin_ok;
      ctrl.victim_shift = apply_go & victim_ok;
      ctrl.unpin_write  = apply_go & unpin_ok;
      ctrl.wr_fid       = fid_ff;
   end

   lfr_chain #(
      .NUM_FRAMES (NUM_FRAMES)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .hit        (hit),
      .head_valid (head_valid),
      .head_value (head_value)
   );

   // capacity register, no read-back
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lfr_pkg::CAPACITY_RST;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   // latch the command word; payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_chan.cmd;
         fid_ff <= req_chan.frame_no;
      end
   end

   // sequencer, occupancy and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (accept) begin
                  state_ff <= ST_APPLY;
               end
            end
            ST_APPLY: begin
               if (apply_go) begin
                  state_ff       <= ST_IDLE;
                  count_ff       <= count_in;
                  rsp_valid_ff   <= 1'b1;
                  rsp_found_ff   <= victim_ok;
                  rsp_victim_ff  <= victim_ok ? head_value : '0;
                  rsp_ignored_ff <= ignored_in;
                  rsp_occ_ff     <= count_in;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.found        = rsp_found_ff;
   assign rsp_chan.victim_frame = rsp_victim_ff;
   assign rsp_chan.ignored      = rsp_ignored_ff;
   assign rsp_chan.occupancy    = rsp_occ_ff;

   // the head cell is occupied exactly when the count is non-zero
   `LFR_ASSERT_SAME(a_head_tracks_count, clock, reset, 1'b1,
                    head_valid == (count_ff != '0))
   // occupancy never exceeds the depth of the row
   `LFR_ASSERT_SAME(a_count_bounded, clock, reset, 1'b1,
                    32'(count_ff) <= NUM_FRAMES)
   // a completed update always presents a result word next cycle
   `LFR_ASSERT_NEXT(a_apply_gives_rsp, clock, reset, apply_go,
                    rsp_valid_ff && (state_ff == ST_IDLE))
   // a returned victim is never also flagged as ignored
   `LFR_ASSERT_SAME(a_found_not_ignored, clock, reset, rsp_valid_ff,
                    !(rsp_found_ff && rsp_ignored_ff))

endmodule

`default_nettype wire
